FILE: rtl/rabe_pkg.sv
`timescale 1ns / 1ps
package rabe_pkg;
  localparam int unsigned XLEN = 64;
  localparam logic [3:0] PcIndex = 4'd15;
  localparam logic [XLEN-1:0] ProgramBytes = 64'd65536;

  typedef enum logic [4:0] {
    OP_AND = 5'd0, OP_XOR = 5'd1, OP_OR = 5'd2, OP_NOT = 5'd3, OP_SHL = 5'd4,
    OP_SHR = 5'd5, OP_ADD = 5'd6, OP_SUB = 5'd7, OP_MUL = 5'd8, OP_DIV = 5'd9,
    OP_NEG = 5'd10, OP_MOD = 5'd11, OP_LT = 5'd12, OP_GT = 5'd13, OP_LE = 5'd14,
    OP_GE = 5'd15, OP_EQ = 5'd16, OP_NEQ = 5'd17, OP_JMP = 5'd18, OP_JZ = 5'd19,
    OP_JNZ = 5'd20, OP_MOV = 5'd21
  } op_e;

  typedef enum logic [1:0] {
    FAULT_NONE = 2'd0, FAULT_DIV_ZERO = 2'd1, FAULT_PC_RANGE = 2'd2
  } fault_e;

  typedef enum logic [2:0] {
    ST_IDLE, ST_READ, ST_ITER, ST_FINISH, ST_OUT
  } state_e;

  // request to the shared iterative unit
  typedef struct packed {
    logic start;
    logic is_mul;
  } iter_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } iter_stat_t;
endpackage

FILE: rtl/register_alu_branch_execute_top.sv
`timescale 1ns / 1ps
// each accepted word is read, then mul, div and mod run through the shared unit, which
// steps one bit a cycle; a divide or modulo by zero skips the unit. The result is then
// committed and held on the output until it is taken.
// one word at a time: input stall is high until the result is taken, so no new word is
// accepted while one is in flight.
// reset: asynchronous active low, register file and pc cleared to zero.
module register_alu_branch_execute_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [4:0]  kind_i,
  input  logic [3:0]  dest_sel_i,
  input  logic [3:0]  src_sel_i,
  input  logic [31:0] immediate_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        write_enable_o,
  output logic [3:0]  written_index_o,
  output logic signed [63:0] written_value_o,
  output logic [15:0] next_pc_o,
  output logic        branch_taken_o,
  output logic [1:0]  fault_o
);
  import rabe_pkg::*;

  state_e state_q, state_d;
  logic [XLEN-1:0] rf_q [16];
  logic [4:0] kind_q;
  logic [3:0] rx_q, ry_q;
  logic [31:0] imm_q;
  logic [XLEN-1:0] a_q, b_q, ua, ub;
  logic na_q, nb_q;
  logic use_imm;
  iter_req_t req;
  iter_stat_t stat;
  logic [XLEN-1:0] prod, quot, rem;

  logic [XLEN-1:0] res, new_pc, len, rq, rr;
  logic wr, taken, dz;
  logic lt, eqv;
  logic commit;

  assign use_imm = (ry_q == 4'd0);
  assign ua = a_q[XLEN-1] ? (XLEN'(0) - a_q) : a_q;
  assign ub = b_q[XLEN-1] ? (XLEN'(0) - b_q) : b_q;

  rabe_iter_unit u_iter (
    .clk_i(clk_i), .rst_ni(rst_ni), .req_i(req),
    .a_i((kind_q == OP_MUL) ? a_q : ua), .b_i((kind_q == OP_MUL) ? b_q : ub),
    .stat_o(stat), .prod_o(prod), .quot_o(quot), .rem_o(rem)
  );

  always_comb begin
    rq = (na_q != nb_q) ? (XLEN'(0) - quot) : quot;
    rr = na_q ? (XLEN'(0) - rem) : rem;
    lt = $signed(a_q) < $signed(b_q);
    eqv = (a_q == b_q);
    len = use_imm ? XLEN'(6) : XLEN'(2);
    res = '0;
    wr = 1'b1;
    taken = 1'b0;
    dz = 1'b0;
    case (kind_q)
      OP_AND: res = a_q & b_q;
      OP_XOR: res = a_q ^ b_q;
      OP_OR:  res = a_q | b_q;
      OP_NOT: begin res = ~a_q; len = XLEN'(2); end
      OP_SHL: res = a_q << b_q[5:0];
      OP_SHR: res = XLEN'($signed(a_q) >>> b_q[5:0]);
      OP_ADD: res = a_q + b_q;
      OP_SUB: res = a_q - b_q;
      OP_MUL: res = prod;
      OP_DIV, OP_MOD: begin
        if (b_q == '0) begin
          dz = 1'b1;
          wr = 1'b0;
        end else begin
          res = (kind_q == OP_DIV) ? rq : rr;
        end
      end
      OP_NEG: begin res = XLEN'(0) - a_q; len = XLEN'(2); end
      OP_LT:  res = XLEN'(lt);
      OP_GT:  res = XLEN'(!lt && !eqv);
      OP_LE:  res = XLEN'(lt || eqv);
      OP_GE:  res = XLEN'(!lt);
      OP_EQ:  res = XLEN'(eqv);
      OP_NEQ: res = XLEN'(!eqv);
      OP_JMP: begin wr = 1'b0; taken = 1'b1; end
      OP_JZ:  begin wr = 1'b0; taken = (a_q == '0); end
      OP_JNZ: begin wr = 1'b0; taken = (a_q != '0); end
      OP_MOV: res = b_q;
      default: begin wr = 1'b0; len = XLEN'(2); end
    endcase
    if (dz) new_pc = rf_q[PcIndex];
    else if (taken) new_pc = use_imm ? XLEN'(imm_q) : a_q;
    else if (wr && rx_q == 4'(PcIndex)) new_pc = res + len;
    else new_pc = rf_q[PcIndex] + len;
  end

  always_comb begin
    state_d = state_q;
    req.start = 1'b0;
    req.is_mul = (kind_q == OP_MUL);
    commit = 1'b0;
    unique case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_READ;
      ST_READ: begin
        if ((kind_q == OP_MUL) ||
            ((kind_q == OP_DIV || kind_q == OP_MOD) && b_q != '0)) begin
          req.start = 1'b1;
          state_d = ST_ITER;
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_ITER: if (stat.done) state_d = ST_FINISH;
      ST_FINISH: begin
        commit = 1'b1;
        state_d = ST_OUT;
      end
      ST_OUT: if (!out_stall_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else state_q <= state_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 16; i++) rf_q[i] <= '0;
    end else if (commit && !dz) begin
      if (wr && !taken && rx_q != 4'(PcIndex)) rf_q[rx_q] <= res;
      rf_q[PcIndex] <= new_pc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i) begin
      kind_q <= kind_i;
      rx_q <= dest_sel_i;
      ry_q <= src_sel_i;
      imm_q <= immediate_i;
    end
    // operands read in the accepting cycle
    if (state_q == ST_IDLE) begin
      a_q <= rf_q[dest_sel_i];
      b_q <= (src_sel_i == 4'd0) ? XLEN'(immediate_i) : rf_q[src_sel_i];
      na_q <= rf_q[dest_sel_i][XLEN-1];
      nb_q <= (src_sel_i == 4'd0) ? 1'b0 : rf_q[src_sel_i][XLEN-1];
    end
    if (commit) begin
      write_enable_o <= wr && !taken && rx_q != 4'(PcIndex);
      written_index_o <= (wr && !taken && rx_q != 4'(PcIndex)) ? rx_q : 4'd0;
      written_value_o <= (wr && !taken && rx_q != 4'(PcIndex)) ? res : '0;
      next_pc_o <= new_pc[15:0];
      branch_taken_o <= taken;
      fault_o <= dz ? FAULT_DIV_ZERO :
                 ((new_pc >= ProgramBytes) ? FAULT_PC_RANGE : FAULT_NONE);
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);
endmodule

FILE: rtl/rabe_iter_unit.sv
`timescale 1ns / 1ps
// shared shift-add multiplier / restoring divider, one bit per cycle
module rabe_iter_unit (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  rabe_pkg::iter_req_t      req_i,
  input  logic [rabe_pkg::XLEN-1:0] a_i,
  input  logic [rabe_pkg::XLEN-1:0] b_i,
  output rabe_pkg::iter_stat_t     stat_o,
  output logic [rabe_pkg::XLEN-1:0] prod_o,
  output logic [rabe_pkg::XLEN-1:0] quot_o,
  output logic [rabe_pkg::XLEN-1:0] rem_o
);
  import rabe_pkg::*;

  logic [6:0] cnt_q, cnt_d;
  logic busy_q, busy_d, done_q, done_d, mul_q, mul_d;
  logic [XLEN-1:0] acc_q, acc_d, sh_q, sh_d, b_q, b_d;
  logic [XLEN:0] trial;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d = cnt_q;
    mul_d = mul_q;
    acc_d = acc_q;
    sh_d = sh_q;
    b_d = b_q;
    trial = {acc_q, sh_q[XLEN-1]} - {1'b0, b_q};
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d = 7'd0;
      mul_d = req_i.is_mul;
      acc_d = '0;
      sh_d = a_i;
      b_d = b_i;
    end else if (busy_q) begin
      if (mul_q) begin
        // sh holds multiplier bits shifted right, b the shifted multiplicand
        if (sh_q[0]) acc_d = acc_q + b_q;
        sh_d = sh_q >> 1;
        b_d = b_q << 1;
      end else begin
        if (!trial[XLEN]) begin
          acc_d = trial[XLEN-1:0];
          sh_d = {sh_q[XLEN-2:0], 1'b1};
        end else begin
          acc_d = {acc_q[XLEN-2:0], sh_q[XLEN-1]};
          sh_d = {sh_q[XLEN-2:0], 1'b0};
        end
      end
      cnt_d = cnt_q + 7'd1;
      if (cnt_q == 7'(XLEN - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
      mul_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
      mul_q <= mul_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    sh_q <= sh_d;
    b_q <= b_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign prod_o = acc_q;
  assign quot_o = sh_q;
  assign rem_o = acc_q;
endmodule

FILE: sim/register_alu_branch_execute_checker.sv
`timescale 1ns / 1ps
module register_alu_branch_execute_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [4:0]  kind_i,
  input  logic [3:0]  dest_sel_i,
  input  logic [3:0]  src_sel_i,
  input  logic [31:0] immediate_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic        write_enable_i,
  input  logic [3:0]  written_index_i,
  input  logic [63:0] written_value_i,
  input  logic [15:0] next_pc_i,
  input  logic        branch_taken_i,
  input  logic [1:0]  fault_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          result_count_o
);
  import rabe_pkg::*;

  typedef struct packed {
    logic        we;
    logic [3:0]  idx;
    logic [63:0] val;
    logic [15:0] pc;
    logic        taken;
    fault_e      fault;
  } exec_result_t;

  logic [63:0] regs [16];
  exec_result_t expected_q [$];

  assign pending_o = expected_q.size();

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
    fail_count_o++;
  endtask

  function automatic exec_result_t execute(input logic [4:0] kind, input logic [3:0] rx,
                                           input logic [3:0] ry, input logic [31:0] imm);
    exec_result_t r;
    logic use_imm;
    logic [63:0] a, b, res, ua, ub, uq, ur, npc, len;
    logic wr, tk, dz;
    use_imm = (ry == 4'd0);
    a = regs[rx];
    b = use_imm ? {32'd0, imm} : regs[ry];
    len = use_imm ? 64'd6 : 64'd2;
    res = '0; wr = 1'b1; tk = 1'b0; dz = 1'b0;
    r = '0;
    case (kind)
      OP_AND: res = a & b;
      OP_XOR: res = a ^ b;
      OP_OR:  res = a | b;
      OP_NOT: begin res = ~a; len = 64'd2; end
      OP_SHL: res = a << b[5:0];
      OP_SHR: res = $signed(a) >>> b[5:0];
      OP_ADD: res = a + b;
      OP_SUB: res = a - b;
      OP_MUL: res = a * b;
      OP_DIV, OP_MOD: begin
        if (b == 0) begin
          dz = 1'b1; wr = 1'b0;
        end else begin
          ua = a[63] ? -a : a;
          ub = b[63] ? -b : b;
          uq = ua / ub;
          ur = ua % ub;
          if (kind == OP_DIV) res = (a[63] != b[63]) ? -uq : uq;
          else res = a[63] ? -ur : ur;
        end
      end
      OP_NEG: begin res = -a; len = 64'd2; end
      OP_LT:  res = {63'd0, $signed(a) <  $signed(b)};
      OP_GT:  res = {63'd0, $signed(a) >  $signed(b)};
      OP_LE:  res = {63'd0, $signed(a) <= $signed(b)};
      OP_GE:  res = {63'd0, $signed(a) >= $signed(b)};
      OP_EQ:  res = {63'd0, a == b};
      OP_NEQ: res = {63'd0, a != b};
      OP_JMP: begin wr = 1'b0; tk = 1'b1; end
      OP_JZ:  begin wr = 1'b0; tk = (a == 0); end
      OP_JNZ: begin wr = 1'b0; tk = (a != 0); end
      OP_MOV: res = b;
      default: begin wr = 1'b0; len = 64'd2; end
    endcase
    if (dz) npc = regs[PcIndex];
    else if (tk) npc = use_imm ? {32'd0, imm} : a;
    else if (wr && rx == PcIndex) npc = res + len;
    else begin
      if (wr) begin
        regs[rx] = res;
        r.we = 1'b1; r.idx = rx; r.val = res;
      end
      npc = regs[PcIndex] + len;
    end
    r.fault = FAULT_NONE;
    if (dz) r.fault = FAULT_DIV_ZERO;
    else begin
      regs[PcIndex] = npc;
      if (npc >= ProgramBytes) r.fault = FAULT_PC_RANGE;
    end
    r.pc = npc[15:0];
    r.taken = tk;
    return r;
  endfunction

  initial begin
    fail_count_o = 0;
    result_count_o = 0;
    foreach (regs[i]) regs[i] = '0;
  end

  always @(posedge clk_i) begin
    exec_result_t want;
    if (rst_ni) begin
      if (out_valid_i && !out_stall_i) begin
        result_count_o++;
        if (expected_q.size() == 0) begin
          report("unexpected word", 64'd1, 64'd0);
        end else begin
          want = expected_q.pop_front();
          if (write_enable_i !== want.we) report("write_enable", write_enable_i, want.we);
          if (written_index_i !== want.idx) report("written_index", written_index_i, want.idx);
          if (written_value_i !== want.val) report("written_value", written_value_i, want.val);
          if (next_pc_i !== want.pc) report("next_pc", next_pc_i, want.pc);
          if (branch_taken_i !== want.taken) report("branch_taken", branch_taken_i, want.taken);
          if (fault_i !== want.fault) report("fault", fault_i, want.fault);
        end
      end
      if (in_valid_i && !in_stall_i)
        expected_q.push_back(execute(kind_i, dest_sel_i, src_sel_i, immediate_i));
    end
  end
endmodule

FILE: sim/register_alu_branch_execute_top_test.sv
`timescale 1ns / 1ps
module register_alu_branch_execute_top_test;
  import rabe_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [4:0]  kind_i = '0;
  logic [3:0]  dest_sel_i = '0;
  logic [3:0]  src_sel_i = '0;
  logic [31:0] immediate_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        write_enable_o;
  logic [3:0]  written_index_o;
  logic signed [63:0] written_value_o;
  logic [15:0] next_pc_o;
  logic        branch_taken_o;
  logic [1:0]  fault_o;
  int fail_count, pending, result_count;
  int cycle_count = 0;
  int stall_mode = 0;

  localparam int CycleLimit = 600000;

  always #10 clk_i = ~clk_i;

  register_alu_branch_execute_top dut (.*);

  register_alu_branch_execute_checker checker_u (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .kind_i, .dest_sel_i,
    .src_sel_i, .immediate_i, .out_valid_i(out_valid_o), .out_stall_i,
    .write_enable_i(write_enable_o), .written_index_i(written_index_o),
    .written_value_i(written_value_o), .next_pc_i(next_pc_o),
    .branch_taken_i(branch_taken_o), .fault_i(fault_o),
    .fail_count_o(fail_count), .pending_o(pending), .result_count_o(result_count)
  );

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("register_alu_branch_execute_top_test: errors");
      $finish;
    end
  end

  // receiver stall pattern: phases of none, light, heavy
  always @(negedge clk_i) begin
    if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 3) == 0);
      default: out_stall_i <= ($urandom_range(0, 3) != 0);
    endcase
  end

  // drive one word, hold until accepted, then drop valid unless next follows
  task automatic send_word(input logic [4:0] k, input logic [3:0] rx, input logic [3:0] ry,
                           input logic [31:0] imm, input bit keep);
    kind_i <= k; dest_sel_i <= rx; src_sel_i <= ry; immediate_i <= imm;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    if (!keep) in_valid_i <= 1'b0;
  endtask

  function automatic logic [31:0] pick_imm();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(0, 63);
      3: return $urandom_range(0, 65535);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int burst;
    logic [4:0] k;
    logic [3:0] rx;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    // directed: extremes, every op, division corners, pc as destination, jumps
    send_word(OP_MOV, 4'd1, 4'd0, 32'hFFFF_FFFF, 0);
    send_word(OP_NEG, 4'd1, 4'd0, 32'd0, 0);          // r1 = -0xffffffff
    send_word(OP_MOV, 4'd2, 4'd0, 32'd1, 0);
    send_word(OP_SHL, 4'd2, 4'd0, 32'd63, 0);         // r2 = most negative
    send_word(OP_MOV, 4'd3, 4'd0, 32'd0, 0);
    send_word(OP_NOT, 4'd3, 4'd0, 32'd0, 0);          // r3 = -1
    send_word(OP_DIV, 4'd2, 4'd3, 32'd0, 0);          // overflow division
    send_word(OP_MOD, 4'd2, 4'd3, 32'd0, 0);
    send_word(OP_DIV, 4'd1, 4'd0, 32'd0, 0);          // divide by zero
    send_word(OP_MOD, 4'd1, 4'd4, 32'd0, 0);          // modulo by zero register
    send_word(OP_MOD, 4'd1, 4'd0, 32'd7, 0);
    send_word(OP_SHR, 4'd3, 4'd0, 32'hFFFF_FFC1, 0);
    for (int op = 0; op <= OP_MOV; op++)
      send_word(op[4:0], 4'd5, op[0] ? 4'd1 : 4'd0, $urandom, 0);
    send_word(5'd31, 4'd15, 4'd15, 32'hFFFF_FFFF, 0);  // unused kind
    send_word(OP_MOV, 4'd15, 4'd0, 32'd100, 0);       // pc as destination
    send_word(OP_JMP, 4'd0, 4'd0, 32'hFFFF_FFFF, 0);  // pc out of range
    send_word(OP_JNZ, 4'd3, 4'd3, 32'd0, 0);          // jump to register value
    send_word(OP_JZ, 4'd0, 4'd0, 32'd0, 0);
    // random: bursts; keep pc mostly in range so runs of ops stay meaningful
    for (int n = 0; n < 850; ) begin
      burst = $urandom_range(1, 12);
      for (int j = 0; j < burst; j++, n++) begin
        k = ($urandom_range(0, 19) == 0) ? 5'($urandom_range(22, 31))
                                          : 5'($urandom_range(0, 21));
        rx = ($urandom_range(0, 15) == 0) ? 4'd15 : 4'($urandom_range(0, 14));
        if ($urandom_range(0, 9) == 0) send_word(OP_JMP, 4'd0, 4'd0,
                                                 $urandom_range(0, 65535), j < burst - 1);
        else send_word(k, rx, 4'($urandom_range(0, 15)), pick_imm(), j < burst - 1);
      end
      if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 20)) @(negedge clk_i);
    end
    while (pending != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
    $display("covered all 22 operations, unused kinds, division corners and pc wraps");
    $display("%0d results checked under random input gaps and output stalls", result_count);
    if (fail_count == 0) $display("register_alu_branch_execute_top_test: clean");
    else $display("register_alu_branch_execute_top_test: errors");
    $finish;
  end
endmodule
